>>> rtl/core/pihex_pkg.sv
// ----------------------------------------------------------------------------
// pihex_pkg
// Shared constants, types and helpers for the paged Intel HEX encoder.
// ----------------------------------------------------------------------------
package pihex_pkg;

   // Geometry
   localparam int RECORD_BYTES     = 32;
   localparam int RECORDS_PER_PAGE = 512;
   localparam int CHUNK_CHARS      = 8;
   localparam int UNITS_PER_CHUNK  = CHUNK_CHARS / 2;
   // byte count, addr hi, addr lo, type, data..., checksum, CR LF
   localparam int LINE_UNITS       = RECORD_BYTES + 6;
   localparam int LINE_CHARS_MAX   = 2 * LINE_UNITS + 1;

   // Widths
   localparam int FILL_W     = $clog2(RECORD_BYTES + 1);
   localparam int RIP_W      = $clog2(RECORDS_PER_PAGE + 1);
   localparam int LINE_IDX_W = $clog2(LINE_UNITS);
   localparam int REM_W      = $clog2(LINE_CHARS_MAX + 1);
   localparam int CNT_W      = 4;
   localparam int ADDR_W     = 16;

   // Fixed line lengths, in characters
   localparam int HEADER_CHARS     = 17;
   localparam int END_CHARS        = 11;
   localparam int DATA_FIXED_CHARS = 13;

   localparam logic [ADDR_W-1:0] BASE_RESET = 16'h4000;

   // Record types and fixed bytes
   localparam logic [7:0] REC_DATA     = 8'h00;
   localparam logic [7:0] REC_EOF      = 8'h01;
   localparam logic [7:0] REC_EXT_SEG  = 8'h02;
   localparam logic [7:0] EXT_SEG_LEN  = 8'h02;
   localparam logic [7:0] EXT_SEG_BASE = 8'h04;
   localparam logic [7:0] EOF_CKSUM    = 8'hFF;

   // Characters
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   // One line unit: two characters, either a hex byte or CR LF
   typedef struct packed {
      logic       crlf;
      logic [7:0] val;
   } unit_type;

   typedef struct packed {
      logic accept;       // latch the request item
      logic load_header;  // load the page header line, open the page
      logic store;        // store the byte, frame the record on flush
      logic load_end;     // load the end line, rewind stream state
      logic emit;         // push one chunk into the output register
      logic last;         // chunk closes this item's results
   } cmd_type;

   typedef struct packed {
      logic page_open;
      logic flush;        // stored byte completes a record
      logic fin;          // latched item is the final byte
      logic line_end;     // next chunk closes the line
      logic slot_free;    // output register can take a chunk
   } status_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'h0, nib};
      if (nib < 4'd10) begin
         return 8'h30 + wide;
      end else begin
         return 8'h37 + wide;
      end
   endfunction

endpackage

>>> rtl/core/pihex_ctrl.sv
// ----------------------------------------------------------------------------
// pihex_ctrl
// Sequencer: accepts items and steps the datapath through header, store,
// record and end-of-file lines.
// ----------------------------------------------------------------------------
module pihex_ctrl
   import pihex_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_STORE     = 6'b000010,
      ST_EMIT_HDR  = 6'b000100,
      ST_EMIT_DATA = 6'b001000,
      ST_LOAD_END  = 6'b010000,
      ST_EMIT_END  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (!status.page_open) begin
                  cmd.load_header = 1'b1;
                  state_in        = ST_EMIT_HDR;
               end else begin
                  state_in = ST_STORE;
               end
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = status.flush ? ST_EMIT_DATA : ST_IDLE;
         end
         ST_EMIT_HDR: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.last = status.line_end && !status.flush;
               if (status.line_end) begin
                  state_in = ST_STORE;
               end
            end
         end
         ST_EMIT_DATA: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.last = status.line_end && !status.fin;
               if (status.line_end) begin
                  state_in = status.fin ? ST_LOAD_END : ST_IDLE;
               end
            end
         end
         ST_LOAD_END: begin
            cmd.load_end = 1'b1;
            state_in     = ST_EMIT_END;
         end
         ST_EMIT_END: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.last = status.line_end;
               if (status.line_end) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_emit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.slot_free)
      else $error("chunk pushed into a full output register");

   a_accept_moves_on: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff == ST_STORE || state_ff == ST_EMIT_HDR))
      else $error("accepted item not followed by store or header");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

endmodule

>>> rtl/core/pihex_dp.sv
// ----------------------------------------------------------------------------
// pihex_dp
// Datapath: line unit shift register, record/page counters, chunk packer
// and output register.
// ----------------------------------------------------------------------------
module pihex_dp
   import pihex_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [7:0]        in_byte,
   input  logic              in_fin,
   input  logic              csr_we,
   input  logic [ADDR_W-1:0] csr_wdata,
   input  logic              out_ready,
   output logic              out_valid,
   output logic [63:0]       out_chunk,
   output logic [CNT_W-1:0]  out_count,
   output logic              out_ends_line,
   output logic              out_last
);

   // Line: ':' followed by two-character units, shifted out four per chunk
   unit_type line_ff [LINE_UNITS];
   unit_type line_in [LINE_UNITS];

   logic [7:0]        byte_ff, carry_ff, carry_in;
   logic              fin_ff;
   logic              first_ff, first_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        sum_ff, sum_in;
   logic [ADDR_W-1:0] base_ff;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [RIP_W-1:0]  rip_ff, rip_in;
   logic [ADDR_W-1:0] page_ff, page_in;
   logic              open_ff, open_in;

   logic              rsp_valid_ff;
   logic [63:0]       rsp_chunk_ff;
   logic [CNT_W-1:0]  rsp_count_ff;
   logic              rsp_ends_ff, rsp_last_ff;

   logic [7:0]            chars [CHUNK_CHARS];
   logic [63:0]           chunk;
   logic [CNT_W-1:0]      count;
   logic [FILL_W-1:0]     fill_next;
   logic [7:0]            sum_next, data_cksum, hdr_cksum;
   logic [LINE_IDX_W-1:0] idx_byte, idx_cksum, idx_crlf;
   logic                  flush;

   function automatic logic [7:0] unit_hi(input unit_type u);
      return u.crlf ? CHAR_CR : hex_char(u.val[7:4]);
   endfunction

   function automatic logic [7:0] unit_lo(input unit_type u);
      return u.crlf ? CHAR_LF : hex_char(u.val[3:0]);
   endfunction

   assign flush = fin_ff || (fill_ff == FILL_W'(RECORD_BYTES - 1));

   assign status.page_open = open_ff;
   assign status.flush     = flush;
   assign status.fin       = fin_ff;
   assign status.line_end  = (rem_ff <= REM_W'(CHUNK_CHARS));
   assign status.slot_free = !rsp_valid_ff || out_ready;

   // Chunk from fixed taps: leading char, three units, high half of fourth
   always_comb begin
      chars[0] = first_ff ? CHAR_COLON : carry_ff;
      for (int u = 0; u < UNITS_PER_CHUNK - 1; u++) begin
         chars[2*u+1] = unit_hi(line_ff[u]);
         chars[2*u+2] = unit_lo(line_ff[u]);
      end
      chars[CHUNK_CHARS-1] = unit_hi(line_ff[UNITS_PER_CHUNK-1]);
      count = status.line_end ? rem_ff[CNT_W-1:0] : CNT_W'(CHUNK_CHARS);
      for (int j = 0; j < CHUNK_CHARS; j++) begin
         chunk[8*j +: 8] = (CNT_W'(j) < count) ? chars[j] : 8'h00;
      end
   end

   assign fill_next  = fill_ff + FILL_W'(1);
   assign sum_next   = sum_ff + byte_ff;
   assign data_cksum = 8'h00 - addr_ff[15:8] - addr_ff[7:0] - sum_next
                     - {{(8-FILL_W){1'b0}}, fill_next};
   assign hdr_cksum  = 8'h00 - EXT_SEG_BASE - page_ff[15:8] - page_ff[7:0];
   assign idx_byte   = LINE_IDX_W'(fill_ff) + LINE_IDX_W'(4);
   assign idx_cksum  = LINE_IDX_W'(fill_ff) + LINE_IDX_W'(5);
   assign idx_crlf   = LINE_IDX_W'(fill_ff) + LINE_IDX_W'(6);

   always_comb begin
      line_in  = line_ff;
      carry_in = carry_ff;
      first_in = first_ff;
      rem_in   = rem_ff;
      fill_in  = fill_ff;
      sum_in   = sum_ff;
      addr_in  = addr_ff;
      rip_in   = rip_ff;
      page_in  = page_ff;
      open_in  = open_ff;

      if (cmd.emit) begin
         for (int i = 0; i < LINE_UNITS; i++) begin
            if (i + UNITS_PER_CHUNK < LINE_UNITS) begin
               line_in[i] = line_ff[i + UNITS_PER_CHUNK];
            end else begin
               line_in[i] = '0;
            end
         end
         carry_in = unit_lo(line_ff[UNITS_PER_CHUNK-1]);
         first_in = 1'b0;
         rem_in   = rem_ff - REM_W'(count);
      end

      if (cmd.load_header) begin
         line_in[0] = '{crlf: 1'b0, val: EXT_SEG_LEN};
         line_in[1] = '{crlf: 1'b0, val: 8'h00};
         line_in[2] = '{crlf: 1'b0, val: 8'h00};
         line_in[3] = '{crlf: 1'b0, val: REC_EXT_SEG};
         line_in[4] = '{crlf: 1'b0, val: page_ff[15:8]};
         line_in[5] = '{crlf: 1'b0, val: page_ff[7:0]};
         line_in[6] = '{crlf: 1'b0, val: hdr_cksum};
         line_in[7] = '{crlf: 1'b1, val: 8'h00};
         first_in   = 1'b1;
         rem_in     = REM_W'(HEADER_CHARS);
         open_in    = 1'b1;
         rip_in     = '0;
         addr_in    = base_ff;
      end

      if (cmd.store) begin
         for (int i = 0; i < LINE_UNITS; i++) begin
            if (LINE_IDX_W'(i) == idx_byte) begin
               line_in[i] = '{crlf: 1'b0, val: byte_ff};
            end
         end
         if (flush) begin
            line_in[0] = '{crlf: 1'b0, val: {{(8-FILL_W){1'b0}}, fill_next}};
            line_in[1] = '{crlf: 1'b0, val: addr_ff[15:8]};
            line_in[2] = '{crlf: 1'b0, val: addr_ff[7:0]};
            line_in[3] = '{crlf: 1'b0, val: REC_DATA};
            for (int i = 0; i < LINE_UNITS; i++) begin
               if (LINE_IDX_W'(i) == idx_cksum) begin
                  line_in[i] = '{crlf: 1'b0, val: data_cksum};
               end
               if (LINE_IDX_W'(i) == idx_crlf) begin
                  line_in[i] = '{crlf: 1'b1, val: 8'h00};
               end
            end
            first_in = 1'b1;
            rem_in   = REM_W'({fill_next, 1'b0}) + REM_W'(DATA_FIXED_CHARS);
            fill_in  = '0;
            sum_in   = '0;
            addr_in  = addr_ff + ADDR_W'(RECORD_BYTES);
            if (rip_ff == RIP_W'(RECORDS_PER_PAGE - 1)) begin
               rip_in  = '0;
               open_in = 1'b0;
               page_in = page_ff + ADDR_W'(1);
            end else begin
               rip_in = rip_ff + RIP_W'(1);
            end
         end else begin
            fill_in = fill_next;
            sum_in  = sum_next;
         end
      end

      if (cmd.load_end) begin
         line_in[0] = '{crlf: 1'b0, val: 8'h00};
         line_in[1] = '{crlf: 1'b0, val: 8'h00};
         line_in[2] = '{crlf: 1'b0, val: 8'h00};
         line_in[3] = '{crlf: 1'b0, val: REC_EOF};
         line_in[4] = '{crlf: 1'b0, val: EOF_CKSUM};
         first_in   = 1'b1;
         rem_in     = REM_W'(END_CHARS);
         fill_in    = '0;
         sum_in     = '0;
         rip_in     = '0;
         page_in    = '0;
         open_in    = 1'b0;
         addr_in    = base_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      line_ff  <= line_in;
      carry_ff <= carry_in;
      if (cmd.accept) begin
         byte_ff <= in_byte;
         fin_ff  <= in_fin;
      end
      if (cmd.emit) begin
         rsp_chunk_ff <= chunk;
         rsp_count_ff <= count;
         rsp_ends_ff  <= status.line_end;
         rsp_last_ff  <= cmd.last;
      end
   end

   // Control and stream state
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= 1'b0;
         rem_ff       <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         base_ff      <= BASE_RESET;
         addr_ff      <= BASE_RESET;
         rip_ff       <= '0;
         page_ff      <= '0;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         first_ff <= first_in;
         rem_ff   <= rem_in;
         fill_ff  <= fill_in;
         sum_ff   <= sum_in;
         addr_ff  <= addr_in;
         rip_ff   <= rip_in;
         page_ff  <= page_in;
         open_ff  <= open_in;
         if (csr_we) begin
            base_ff <= csr_wdata;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign out_valid     = rsp_valid_ff;
   assign out_chunk     = rsp_chunk_ff;
   assign out_count     = rsp_count_ff;
   assign out_ends_line = rsp_ends_ff;
   assign out_last      = rsp_last_ff;

   a_closed_page_clean: assert property (@(posedge clock) disable iff (reset)
      !open_ff |-> (rip_ff == '0 && fill_ff == '0))
      else $error("page closed with record state pending");

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff < FILL_W'(RECORD_BYTES))
      else $error("fill count past record size");

   a_rem_in_range: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= REM_W'(LINE_CHARS_MAX))
      else $error("line character count out of range");

endmodule

>>> rtl/core/paged_intel_hex_encoder_core.sv
// ----------------------------------------------------------------------------
// paged_intel_hex_encoder_core
// Binary bytes in, Intel HEX text out, up to eight characters per item.
// Each request item is one image byte (tlast marks the final byte). Each
// 32-byte record leaves as one ":NNAAAA00...CC" line with CR LF, cut into
// chunks of eight characters (the last chunk of a line may be shorter; a
// line always starts a new chunk). Every page of 512 records opens with a
// type-02 line carrying the page number, and addresses restart at the
// base address each page. The final byte flushes its record and is followed
// by ":00000001FF" (no CR LF); the next byte starts a new file at page 0.
// A byte that does not complete a record is accepted, then stored.
// Emitting a line pushes one chunk per cycle while the output register
// has room: three chunks for a page header, up to ten for a full record,
// two for the end line, which is loaded first. No new byte is taken
// until the chunks of the last one are out. Output back-pressure stalls
// emission with no loss. The load base address is sampled when a page
// opens; write it only while idle.
// ----------------------------------------------------------------------------
module paged_intel_hex_encoder_core
   import pihex_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // request: one image byte per item
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] data_byte
   input  logic              req_tlast,   // final_byte
   // response: one text chunk per item
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [71:0]       rsp_tdata,   // [63:0] text_chunk, [67:64] char_count
   output logic              rsp_tuser,   // [0] ends_line
   output logic              rsp_tlast,   // last_of_run
   // configuration: load base address
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [ADDR_W-1:0] csr_data
);

   cmd_type          cmd;
   status_type       status;
   logic [63:0]      chunk;
   logic [CNT_W-1:0] count;

   // Register always writable; contract keeps writes to idle periods
   assign csr_ready = 1'b1;

   pihex_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pihex_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .in_byte       (req_tdata),
      .in_fin        (req_tlast),
      .csr_we        (csr_valid && csr_ready),
      .csr_wdata     (csr_data),
      .out_ready     (rsp_tready),
      .out_valid     (rsp_tvalid),
      .out_chunk     (chunk),
      .out_count     (count),
      .out_ends_line (rsp_tuser),
      .out_last      (rsp_tlast)
   );

   // Pack response: chunk low, count above, zero pad to whole bytes
   assign rsp_tdata = {4'h0, count, chunk};

endmodule

>>> bench/tb_paged_intel_hex_encoder_core.sv
// ----------------------------------------------------------------------------
// tb_paged_intel_hex_encoder_core
// Self-checking bench for the paged Intel HEX encoder. Image bytes go in
// over the req_ stream. A cycle-free model of the encoder builds every
// record line (page header, data record, end record), cuts it into chunks of
// eight characters and queues them. The rsp_ stream is then checked chunk by
// chunk against that queue. The run covers the reset base address, both
// extremes (the high one with address wrap), a random one and 0xFFF0.
// Both sides idle in random bursts until the last part of the run.
// ----------------------------------------------------------------------------
module tb_paged_intel_hex_encoder_core
   import pihex_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 12;    // a byte that fills no record is accepted, then stored
   localparam int TAIL_IMAGE    = 20;

   // Intel HEX record types and characters
   localparam logic [7:0] TYPE_DATA    = 8'h00;
   localparam logic [7:0] TYPE_EOF     = 8'h01;
   localparam logic [7:0] TYPE_PAGE    = 8'h02;
   localparam logic [7:0] ASCII_COLON  = 8'h3A;
   localparam logic [7:0] ASCII_CR     = 8'h0D;
   localparam logic [7:0] ASCII_LF     = 8'h0A;
   localparam logic [7:0] ASCII_ZERO   = 8'h30;
   localparam logic [7:0] ASCII_UPPERA = 8'h41;

   typedef struct packed {
      logic [7:0] data;
      logic       fin;
   } image_byte_type;

   typedef struct packed {
      logic [63:0] text;
      logic [3:0]  count;
      logic        eol;
      logic        last;
   } text_chunk_type;

   // DUT ports; every input known from time zero
   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata  = 8'h00;
   logic              req_tlast  = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [71:0]       rsp_tdata;
   logic              rsp_tuser;
   logic              rsp_tlast;
   logic              csr_valid  = 1'b0;
   logic              csr_ready;
   logic [ADDR_W-1:0] csr_data   = '0;

   // encoder model state, reset values
   logic [7:0]        record_bytes[$];
   logic [7:0]        record_payload[$];
   logic [7:0]        line_chars[$];
   logic [15:0]       record_addr  = BASE_RESET;
   logic [15:0]       page_num     = 16'h0000;
   int                page_records = 0;
   bit                page_is_open = 1'b0;
   logic [15:0]       base_cfg     = BASE_RESET;

   text_chunk_type    run_chunks[$];
   text_chunk_type    expected_chunks[$];
   text_chunk_type    want;
   image_byte_type    pending_bytes[$];

   int                mismatches = 0;
   int                cycle_count = 0;
   bit                idle_enable = 1'b1;
   int                gap_left = 0;
   int                send_calm = 0;
   int                stall_left = 0;
   int                recv_calm = 0;

   paged_intel_hex_encoder_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Encoder model
   // ------------------------------------------------------------------------
   function automatic logic [7:0] nibble_ascii(input logic [3:0] n);
      if (n < 4'd10) begin
         return ASCII_ZERO + {4'h0, n};
      end else begin
         return ASCII_UPPERA + {4'h0, n} - 8'd10;
      end
   endfunction

   task automatic put_hex(input logic [7:0] v);
      line_chars.push_back(nibble_ascii(v[7:4]));
      line_chars.push_back(nibble_ascii(v[3:0]));
   endtask

   // One Intel HEX line from record_payload; the checksum is the two's
   // complement of count, address, type and payload bytes. Lines go out
   // in chunks of eight, a line never shares a chunk.
   task automatic format_record(input logic [7:0] rtype, input logic [15:0] addr,
                                input bit crlf);
      logic [7:0]     sum;
      logic [7:0]     len;
      text_chunk_type c;
      int             pos;
      int             cnt;
      len = 8'(record_payload.size());
      sum = len + addr[15:8] + addr[7:0] + rtype;
      line_chars = {};
      line_chars.push_back(ASCII_COLON);
      put_hex(len);
      put_hex(addr[15:8]);
      put_hex(addr[7:0]);
      put_hex(rtype);
      foreach (record_payload[i]) begin
         put_hex(record_payload[i]);
         sum = sum + record_payload[i];
      end
      put_hex(8'h00 - sum);
      if (crlf) begin
         line_chars.push_back(ASCII_CR);
         line_chars.push_back(ASCII_LF);
      end
      pos = 0;
      while (pos < line_chars.size()) begin
         cnt = line_chars.size() - pos;
         if (cnt > 8) cnt = 8;
         c = '0;
         for (int k = 0; k < cnt; k++) begin
            c.text[8*k +: 8] = line_chars[pos + k];
         end
         c.count = 4'(cnt);
         pos += cnt;
         c.eol = (pos >= line_chars.size());
         run_chunks.push_back(c);
      end
   endtask

   // Everything one accepted byte causes, appended to expected_chunks.
   task automatic encode_byte(input logic [7:0] b, input logic fin);
      text_chunk_type c;
      run_chunks = {};
      if (!page_is_open) begin
         // first byte of a page: header line, address restarts at base
         page_is_open = 1'b1;
         page_records = 0;
         record_addr  = base_cfg;
         record_payload = {page_num[15:8], page_num[7:0]};
         format_record(TYPE_PAGE, 16'h0000, 1'b1);
      end
      record_bytes.push_back(b);
      if (record_bytes.size() >= RECORD_BYTES || fin) begin
         record_payload = record_bytes;
         format_record(TYPE_DATA, record_addr, 1'b1);
         record_bytes = {};
         record_addr  = record_addr + 16'(RECORD_BYTES);  // wraps at 16 bits
         page_records++;
         if (page_records >= RECORDS_PER_PAGE) begin
            page_records = 0;
            page_is_open = 1'b0;
            page_num     = page_num + 16'd1;
         end
      end
      if (fin) begin
         // end line has no CR LF; the next byte starts a new file at page 0
         record_payload = {};
         format_record(TYPE_EOF, 16'h0000, 1'b0);
         page_records = 0;
         page_num     = 16'h0000;
         page_is_open = 1'b0;
         record_addr  = base_cfg;
      end
      if (run_chunks.size() > 0) begin
         c = run_chunks.pop_back();
         c.last = 1'b1;
         run_chunks.push_back(c);
      end
      foreach (run_chunks[i]) expected_chunks.push_back(run_chunks[i]);
   endtask

   // ------------------------------------------------------------------------
   // Request driver: feeds pending_bytes, random idle bursts between items
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) void'(pending_bytes.pop_front());
         if (req_tvalid && !req_tready) begin
            // item held until taken
         end else if (gap_left > 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_bytes.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (idle_enable && send_calm == 0 && $urandom_range(0, 3) == 0) begin
            // idle burst, then a calm stretch
            gap_left   <= $urandom_range(0, 15);
            send_calm  <= $urandom_range(0, 24);
            req_tvalid <= 1'b0;
         end else begin
            if (send_calm > 0) send_calm <= send_calm - 1;
            req_tvalid <= 1'b1;
            req_tdata  <= pending_bytes[0].data;
            req_tlast  <= pending_bytes[0].fin;
         end
      end
   end

   // Response sink: random stall bursts, independent of rsp_tvalid
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (recv_calm > 0) begin
         recv_calm  <= recv_calm - 1;
         rsp_tready <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 15);
         recv_calm  <= $urandom_range(0, 60);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: predict on accepted request items, check response items
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) encode_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chunks.size() == 0) begin
               $error("unexpected chunk: tdata %h tuser %b tlast %b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               mismatches++;
            end else begin
               want = expected_chunks.pop_front();
               if (rsp_tdata[63:0] !== want.text) begin
                  $error("text_chunk: expected %h, got %h", want.text, rsp_tdata[63:0]);
                  mismatches++;
               end
               if (rsp_tdata[67:64] !== want.count) begin
                  $error("char_count: expected %0d, got %0d", want.count, rsp_tdata[67:64]);
                  mismatches++;
               end
               if (rsp_tuser !== want.eol) begin
                  $error("ends_line: expected %b, got %b", want.eol, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_of_run: expected %b, got %b", want.last, rsp_tlast);
                  mismatches++;
               end
            end
         end
      end
   end

   // hard stop
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] d, input logic fin);
      image_byte_type item;
      item.data = d;
      item.fin  = fin;
      pending_bytes.push_back(item);
   endtask

   // Mostly whole images of random content around the record boundaries;
   // some noise (final flags anywhere) and unterminated runs.
   task automatic queue_random_images(input int min_items);
      int added;
      int len;
      int shape;
      bit terminated;
      bit noisy;
      added = 0;
      while (added < min_items) begin
         shape      = $urandom_range(0, 9);
         terminated = 1'b1;
         noisy      = 1'b0;
         case (shape)
            0, 1: len = $urandom_range(1, 4);
            2, 3: len = $urandom_range(5, 30);
            4, 5: len = $urandom_range(31, 33);     // around a full record
            6:    len = $urandom_range(63, 65);     // two records
            7:    len = $urandom_range(34, 62);
            8: begin
               len   = $urandom_range(1, 20);
               noisy = 1'b1;
               terminated = $urandom_range(0, 1);
            end
            default: begin
               len = $urandom_range(1, 40);
               terminated = 1'b0;
            end
         endcase
         for (int i = 0; i < len; i++) begin
            push_byte(8'($urandom_range(0, 255)),
                      (terminated && i == len - 1) ||
                      (noisy && $urandom_range(0, 5) == 0));
         end
         added += len;
      end
   endtask

   // wait for the stream to run dry, then let the block settle
   task automatic drain();
      while (pending_bytes.size() != 0 || req_tvalid || expected_chunks.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_base(input logic [15:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      base_cfg = v;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed, reset base 0x4000
      @(negedge clock);
      push_byte(8'h00, 1'b1);      // one-byte image: header, record, end
      push_byte(8'hFF, 1'b1);
      push_byte(8'h80, 1'b0);      // short record flushed by the final byte
      push_byte(8'h7F, 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(8'hFE, 1'b1);
      push_byte(8'h55, 1'b0);      // left open across the next phase
      push_byte(8'hAA, 1'b0);
      drain();

      // low extreme
      write_base(16'h0000);
      @(negedge clock);
      queue_random_images(8);
      drain();

      // high extreme: record addresses wrap past 0xFFFF
      write_base(16'hFFFF);
      @(negedge clock);
      queue_random_images(8);
      drain();

      write_base(16'($urandom_range(1, 16'hFFFE)));
      @(negedge clock);
      queue_random_images(8);
      drain();

      // last part, no idling: one image near the top of the address space
      @(negedge clock);
      idle_enable = 1'b0;
      write_base(16'hFFF0);
      @(negedge clock);
      for (int i = 0; i < TAIL_IMAGE; i++) begin
         push_byte(8'($urandom_range(0, 255)), i == TAIL_IMAGE - 1);
      end
      drain();

      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/pihex_pkg.sv
rtl/core/pihex_ctrl.sv
rtl/core/pihex_dp.sv
rtl/core/paged_intel_hex_encoder_core.sv
bench/tb_paged_intel_hex_encoder_core.sv
